>>> src/byte_fifo_in_word_sram_defines.svh
// Assertion macros shared by the byte FIFO checker.
`ifndef BYTE_FIFO_IN_WORD_SRAM_DEFINES_SVH
`define BYTE_FIFO_IN_WORD_SRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BFIFO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfifo check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BFIFO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfifo check failed");

`endif

>>> src/bfifo_pkg.sv
// Shared constants, codes and types of the byte FIFO in word memory.
package bfifo_pkg;

	localparam int BUFFER_BYTES = 2048;
	localparam int OFF_W        = $clog2(BUFFER_BYTES);
	localparam int CNT_W        = OFF_W + 1;
	localparam int AW           = CNT_W + 1;
	localparam int WORD_COUNT   = BUFFER_BYTES / 4;
	localparam int IDX_W        = $clog2(WORD_COUNT);
	localparam int MIN_SIZE     = 4;

	localparam int FILL_W       = 12;
	localparam int CFG_SIZE_W   = 12;
	localparam int RESERVE_W    = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;
	localparam int SZ_W         = (CNT_W > CFG_SIZE_W) ? CNT_W : CFG_SIZE_W;

	localparam logic [CFG_SIZE_W-1:0] SIZE_RST    = CFG_SIZE_W'(2048);
	localparam logic [RESERVE_W-1:0]  RESERVE_RST = RESERVE_W'(4);
	localparam logic [1:0]            LANE_MASK   = 2'h3;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIFO_SIZE = 2'd0,
		REG_RESERVE   = 2'd1
	} cfg_reg_t;

	// Requests from the sequencer to the pointer unit.
	typedef struct packed {
		logic                  cfg_we;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_data;
		logic                  adv_wr;
		logic                  adv_rd;
	} ptr_ctrl_t;

	// Status of the pointer unit.
	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic             push_ok;
		logic             pop_ok;
		logic [OFF_W-1:0] wr_off;
		logic [OFF_W-1:0] rd_off;
	} ptr_stat_t;

endpackage

>>> src/bfifo_ptr.sv
// Pointer unit: size and reserve registers, phase-bit pointers, fill level.
module bfifo_ptr import bfifo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ptr_ctrl_t ctrl,
	output ptr_stat_t stat
);

	logic [CFG_SIZE_W-1:0] size_q;
	logic [RESERVE_W-1:0]  reserve_q;
	logic [OFF_W-1:0]      wr_off_q;
	logic [OFF_W-1:0]      rd_off_q;
	logic                  wr_ph_q;
	logic                  rd_ph_q;

	logic [SZ_W-1:0]  size_x;
	logic [CNT_W-1:0] eff_size;
	logic [AW-1:0]    s_a;
	logic [AW-1:0]    w_a;
	logic [AW-1:0]    r_a;
	logic [AW-1:0]    f_a;
	logic [AW-1:0]    wr_inc;
	logic [AW-1:0]    rd_inc;
	logic             wr_wrap;
	logic             rd_wrap;

	// Clamp the configured size into the usable range
	always_comb begin
		size_x = SZ_W'(size_q);
		if (size_x < SZ_W'(MIN_SIZE)) begin
			eff_size = CNT_W'(MIN_SIZE);
		end else if (size_x > SZ_W'(BUFFER_BYTES)) begin
			eff_size = CNT_W'(BUFFER_BYTES);
		end else begin
			eff_size = CNT_W'(size_x);
		end
	end

	// Derive the fill level from offsets and phases
	always_comb begin
		s_a = AW'(eff_size);
		w_a = AW'(wr_off_q);
		r_a = AW'(rd_off_q);
		if (wr_ph_q == rd_ph_q) begin
			f_a = (w_a >= r_a) ? w_a - r_a : '0;
		end else begin
			f_a = (s_a + w_a >= r_a) ? s_a + w_a - r_a : '0;
		end
		if (f_a > s_a) begin
			f_a = s_a;
		end
	end

	// Advance with wrap at the effective size
	assign wr_inc  = AW'(wr_off_q) + AW'(1);
	assign rd_inc  = AW'(rd_off_q) + AW'(1);
	assign wr_wrap = (wr_inc >= s_a);
	assign rd_wrap = (rd_inc >= s_a);

	assign stat.fill    = CNT_W'(f_a);
	assign stat.push_ok = (f_a + AW'(reserve_q)) < s_a;
	assign stat.pop_ok  = (f_a != '0);
	assign stat.wr_off  = wr_off_q;
	assign stat.rd_off  = rd_off_q;

	// Take register writes, else advance pointers on committed requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_RST;
			reserve_q <= RESERVE_RST;
			wr_off_q  <= '0;
			rd_off_q  <= '0;
			wr_ph_q   <= 1'b0;
			rd_ph_q   <= 1'b0;
		end else if (ctrl.cfg_we) begin
			unique case (ctrl.cfg_idx)
				REG_FIFO_SIZE: begin
					size_q   <= ctrl.cfg_data[CFG_SIZE_W-1:0];
					wr_off_q <= '0;
					rd_off_q <= '0;
					wr_ph_q  <= 1'b0;
					rd_ph_q  <= 1'b0;
				end
				REG_RESERVE: begin
					reserve_q <= ctrl.cfg_data[RESERVE_W-1:0];
				end
				default: begin
				end
			endcase
		end else begin
			if (ctrl.adv_wr) begin
				wr_off_q <= wr_wrap ? '0 : OFF_W'(wr_inc);
				wr_ph_q  <= wr_ph_q ^ wr_wrap;
			end
			if (ctrl.adv_rd) begin
				rd_off_q <= rd_wrap ? '0 : OFF_W'(rd_inc);
				rd_ph_q  <= rd_ph_q ^ rd_wrap;
			end
		end
	end

endmodule

>>> src/byte_fifo_in_word_sram.sv
// Byte FIFO over a 512 x 32 word memory; no new request is taken while busy is high.
// Latency: the result strobe done rises the cycle after start is taken.
// Requests are serialised by the single-port memory read-modify-write (read in the
// accept cycle, merge and write back in the next for a push); busy covers the second.
// Reset: pointers to zero, fifo_size 2048, reserve_bytes 4; memory words stay
// undefined until pushed, with no clearing pass.
module byte_fifo_in_word_sram import bfifo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [7:0]            data_byte,
	output logic                  done,
	output logic                  accepted,
	output logic [7:0]            read_byte,
	output logic [FILL_W-1:0]     fill_bytes,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [31:0] mem [WORD_COUNT];

	logic             valid_s1;
	logic             kind_s1;
	logic             acc_s1;
	logic [7:0]       data_s1;
	logic [1:0]       lane_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      rdata_q;

	ptr_ctrl_t        ctrl;
	ptr_stat_t        stat;
	logic             take;
	logic             push_go;
	logic             pop_go;
	logic [OFF_W-1:0] off_sel;
	logic [31:0]      wdata;
	logic             wr_en;

	bfifo_ptr u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	// Decide the request against the current pointers
	assign take      = start & ~valid_s1;
	assign push_go   = take & (kind == KIND_PUSH) & stat.push_ok;
	assign pop_go    = take & (kind == KIND_POP) & stat.pop_ok;
	assign off_sel   = (kind == KIND_POP) ? stat.rd_off : stat.wr_off;
	assign cfg_ready = 1'b1;

	always_comb begin
		ctrl.cfg_we   = cfg_valid & cfg_ready;
		ctrl.cfg_idx  = cfg_index;
		ctrl.cfg_data = cfg_data;
		ctrl.adv_wr   = push_go;
		ctrl.adv_rd   = pop_go;
	end

	// Hold the request for the write-back cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1 <= kind;
			acc_s1  <= push_go | pop_go;
			data_s1 <= data_byte;
			lane_s1 <= off_sel[1:0] & LANE_MASK;
			idx_s1  <= off_sel[OFF_W-1:2];
		end
	end

	// Merge the pushed byte into its lane
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			wdata[l*8 +: 8] = (lane_s1 == 2'(l)) ? data_s1 : rdata_q[l*8 +: 8];
		end
	end

	assign wr_en = valid_s1 & acc_s1 & (kind_s1 == KIND_PUSH);

	// Read the word at accept, write the merged word of an accepted push back in the cycle after
	always_ff @(posedge clk) begin
		if (take) begin
			rdata_q <= mem[off_sel[OFF_W-1:2]];
		end
		if (wr_en) begin
			mem[idx_s1] <= wdata;
		end
	end

	// Drive the result from the updated pointers and the read word
	assign busy       = valid_s1;
	assign done       = valid_s1;
	assign accepted   = acc_s1;
	assign read_byte  = (acc_s1 & (kind_s1 == KIND_POP)) ? rdata_q[{lane_s1, 3'b000} +: 8]
		: 8'h00;
	assign fill_bytes = FILL_W'(stat.fill);

endmodule

>>> src/bfifo_chk.sv
// Port-level checker for the byte FIFO, bound to the top level.
`include "byte_fifo_in_word_sram_defines.svh"

module bfifo_chk import bfifo_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              accepted,
	input logic [7:0]        read_byte,
	input logic [FILL_W-1:0] fill_bytes
);

	// Every taken request answers on the next cycle
	`BFIFO_ASSERT_NEXT(a_done_follows, start && !busy, done)

	// Results never come back to back
	`BFIFO_ASSERT_NEXT(a_done_single, done, !done)

	// A refused request returns a zero byte
	`BFIFO_ASSERT_NOW(a_refused_zero, done && !accepted, read_byte == 8'h00)

	// The fill level never exceeds the buffer while a result is shown
	`BFIFO_ASSERT_NOW(a_fill_bound, done, fill_bytes <= FILL_W'(BUFFER_BYTES))

endmodule

bind byte_fifo_in_word_sram bfifo_chk u_bfifo_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.accepted   (accepted),
	.read_byte  (read_byte),
	.fill_bytes (fill_bytes)
);

>>> tb/tb_byte_fifo_in_word_sram.sv
// Self-checking testbench for the byte FIFO kept in a word memory.
module tb_byte_fifo_in_word_sram;
	import bfifo_pkg::*;

	// Indexes past the two registers; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_ITEMS  = 260;
	localparam int WRAP_SIZE     = 96;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SCRIPT_LEN    = 27;

	typedef struct packed {
		logic              acc;
		logic [7:0]        byte_out;
		logic [FILL_W-1:0] fill;
	} fifo_result_t;

	typedef enum logic [1:0] {
		ROW_PUSH,
		ROW_POP,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		row_op_t               op;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] value;
		logic                  typed;
		fifo_result_t          want;
	} script_row_t;

	localparam fifo_result_t NO_RESULT = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  kind;
	logic [7:0]            data_byte;
	logic                  done;
	logic                  accepted;
	logic [7:0]            read_byte;
	logic [FILL_W-1:0]     fill_bytes;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predicted contents and pointers of the FIFO
	logic [31:0]           word_copy [WORD_COUNT];
	logic [OFF_W-1:0]      wr_off;
	logic [OFF_W-1:0]      rd_off;
	logic                  wr_phase;
	logic                  rd_phase;
	logic [CFG_SIZE_W-1:0] size_copy;
	logic [RESERVE_W-1:0]  reserve_copy;

	fifo_result_t pending_results [$];
	fifo_result_t oldest;
	int           mismatch_count;
	int           cycle_count;
	bit           no_gaps;

	// Directed requests: empty pop at reset, byte extremes, minimum size with a wrap,
	// full push, large reserve, unused register indexes, size clamped from above
	script_row_t script_rows [SCRIPT_LEN] = '{
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b1, '{1'b0, 8'h00, 12'd0}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h000, 1'b1, '{1'b1, 8'h00, 12'd1}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h0ff, 1'b1, '{1'b1, 8'h00, 12'd2}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h0a5, 1'b1, '{1'b1, 8'h00, 12'd3}},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h0ff, 1'b1, '{1'b1, 8'h00, 12'd2}},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b1, '{1'b1, 8'hff, 12'd1}},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h05a, 1'b1, '{1'b1, 8'ha5, 12'd0}},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b1, '{1'b0, 8'h00, 12'd0}},
		'{ROW_CFG,  REG_FIFO_SIZE, 12'h000, 1'b0, NO_RESULT},
		'{ROW_CFG,  REG_RESERVE,   12'h000, 1'b0, NO_RESULT},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h011, 1'b1, '{1'b1, 8'h00, 12'd1}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h022, 1'b1, '{1'b1, 8'h00, 12'd2}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h033, 1'b1, '{1'b1, 8'h00, 12'd3}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h044, 1'b1, '{1'b1, 8'h00, 12'd4}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h055, 1'b1, '{1'b0, 8'h00, 12'd4}},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b1, '{1'b1, 8'h11, 12'd3}},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h066, 1'b1, '{1'b1, 8'h00, 12'd4}},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b0, NO_RESULT},
		'{ROW_CFG,  REG_RESERVE,   12'hfff, 1'b0, NO_RESULT},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h077, 1'b1, '{1'b0, 8'h00, 12'd3}},
		'{ROW_CFG,  REG_SPARE_2,   12'hfff, 1'b0, NO_RESULT},
		'{ROW_CFG,  REG_SPARE_3,   12'h000, 1'b0, NO_RESULT},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b0, NO_RESULT},
		'{ROW_CFG,  REG_FIFO_SIZE, 12'hfff, 1'b0, NO_RESULT},
		'{ROW_POP,  REG_FIFO_SIZE, 12'h000, 1'b1, '{1'b0, 8'h00, 12'd0}},
		'{ROW_CFG,  REG_RESERVE,   12'h008, 1'b0, NO_RESULT},
		'{ROW_PUSH, REG_FIFO_SIZE, 12'h080, 1'b0, NO_RESULT}
	};

	byte_fifo_in_word_sram uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.data_byte  (data_byte),
		.done       (done),
		.accepted   (accepted),
		.read_byte  (read_byte),
		.fill_bytes (fill_bytes),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Size in use: the register clamped to what the buffer allows
	function automatic int live_size();
		int s;
		s = int'(size_copy);
		if (s < MIN_SIZE) s = MIN_SIZE;
		if (s > BUFFER_BYTES) s = BUFFER_BYTES;
		return s;
	endfunction

	// Bytes held, from the offsets and phase bits
	function automatic int held_bytes();
		int s;
		int f;
		s = live_size();
		if (wr_phase == rd_phase)
			f = (wr_off >= rd_off) ? int'(wr_off) - int'(rd_off) : 0;
		else
			f = (s + int'(wr_off) >= int'(rd_off)) ? s + int'(wr_off) - int'(rd_off) : 0;
		if (f > s) f = s;
		return f;
	endfunction

	// Step a pointer by one byte, flipping its phase on wrap
	task automatic advance_ptr(inout logic [OFF_W-1:0] off, inout logic phase);
		if (int'(off) + 1 >= live_size()) begin
			off = '0;
			phase = ~phase;
		end else begin
			off = off + 1'b1;
		end
	endtask

	// Predict one push or pop and update the FIFO copy
	task automatic step_byte_fifo(input logic k, input logic [7:0] d, output fifo_result_t r);
		int fill;
		fill = held_bytes();
		r = '0;
		if (k == KIND_PUSH) begin
			if (fill + int'(reserve_copy) < live_size()) begin
				word_copy[wr_off[OFF_W-1:2]][8*wr_off[1:0] +: 8] = d;
				advance_ptr(wr_off, wr_phase);
				r.acc = 1'b1;
			end
		end else if (fill != 0) begin
			r.byte_out = word_copy[rd_off[OFF_W-1:2]][8*rd_off[1:0] +: 8];
			advance_ptr(rd_off, rd_phase);
			r.acc = 1'b1;
		end
		r.fill = FILL_W'(held_bytes());
	endtask

	// Mirror a register write; a size write flushes the FIFO
	task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		if (idx == REG_FIFO_SIZE) begin
			size_copy = val[CFG_SIZE_W-1:0];
			wr_off = '0;
			rd_off = '0;
			wr_phase = 1'b0;
			rd_phase = 1'b0;
		end else if (idx == REG_RESERVE) begin
			reserve_copy = val[RESERVE_W-1:0];
		end
	endtask

	// Hold off at random, then present one request until it is taken
	task automatic issue_request(input logic k, input logic [7:0] d, input logic typed,
			input fifo_result_t want);
		int gap;
		fifo_result_t got;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		data_byte <= d;
		do @(posedge clk); while (busy);
		step_byte_fifo(k, d, got);
		pending_results.push_back(typed ? want : got);
	endtask

	// Drain outstanding requests, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int gap;
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		gap = $urandom_range(0, 10);
		repeat (gap) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg_write(idx, val);
	endtask

	// Compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatch_count++;
			end else begin
				oldest = pending_results.pop_front();
				if (accepted !== oldest.acc) begin
					$error("accepted: expected %0d, actual %0d", oldest.acc, accepted);
					mismatch_count++;
				end
				if (read_byte !== oldest.byte_out) begin
					$error("read_byte: expected %0h, actual %0h", oldest.byte_out, read_byte);
					mismatch_count++;
				end
				if (fill_bytes !== oldest.fill) begin
					$error("fill_bytes: expected %0d, actual %0d", oldest.fill, fill_bytes);
					mismatch_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		script_row_t row;
		int sz;
		int rsv;
		int mode;
		int phase_len;
		int push_pct;
		int random_items;
		logic k;

		mismatch_count = 0;
		cycle_count = 0;
		no_gaps = 1'b0;
		random_items = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_PUSH;
		data_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FIFO_SIZE;
		cfg_data <= '0;
		wr_off = '0;
		rd_off = '0;
		wr_phase = 1'b0;
		rd_phase = 1'b0;
		size_copy = SIZE_RST;
		reserve_copy = RESERVE_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row = script_rows[i];
			case (row.op)
				ROW_CFG: begin
					write_reg(row.reg_idx, row.value);
				end
				ROW_PUSH: begin
					issue_request(KIND_PUSH, row.value[7:0], row.typed, row.want);
				end
				default: begin
					issue_request(KIND_POP, row.value[7:0], row.typed, row.want);
				end
			endcase
		end

		// Random phases: new settings, then a balanced or biased run of pushes and pops
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0: sz = $urandom_range(0, MIN_SIZE - 1);
					1: sz = $urandom_range(BUFFER_BYTES + 1, 4095);
					2: sz = $urandom_range(MIN_SIZE, 4095);
					default: sz = $urandom_range(MIN_SIZE, 48);
				endcase
				write_reg(REG_FIFO_SIZE, CFG_DATA_W'(sz));
			end
			rsv = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			write_reg(REG_RESERVE, {8'($urandom_range(0, 255)), 4'(rsv)});
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					CFG_DATA_W'($urandom));
			mode = $urandom_range(0, 3);
			phase_len = $urandom_range(30, 60);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < phase_len; i++) begin
				case (mode)
					0: push_pct = 50;
					1: push_pct = (i < phase_len / 2) ? 85 : 15;
					2: push_pct = 85;
					default: push_pct = 20;
				endcase
				k = ($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_POP;
				issue_request(k, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
				random_items++;
			end
			no_gaps = 1'b0;
		end

		// Fill a mid-size buffer past full so the write pointer wraps, then pop three and push three
		write_reg(REG_FIFO_SIZE, CFG_DATA_W'(WRAP_SIZE));
		write_reg(REG_RESERVE, '0);
		no_gaps = 1'b1;
		for (int i = 0; i <= WRAP_SIZE; i++)
			issue_request(KIND_PUSH, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
		no_gaps = 1'b0;
		for (int i = 0; i < 3; i++)
			issue_request(KIND_POP, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
		for (int i = 0; i < 3; i++)
			issue_request(KIND_PUSH, 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);

		// Let the last results arrive
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/bfifo_pkg.sv
src/bfifo_ptr.sv
src/byte_fifo_in_word_sram.sv
src/bfifo_chk.sv
tb/tb_byte_fifo_in_word_sram.sv
